@@ rtl/sktbl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktbl_pkg
// Word types, operation and result codes shared by the sorted key table.
// ----------------------------------------------------------------------------
package sktbl_pkg;

    localparam int KEY_W   = 31;
    localparam int AGE_W   = 8;
    localparam int COUNT_W = 5;

    // Operation codes carried in the kind field
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;
    localparam logic [1:0] KIND_DELETE = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    // Where a successful insert landed
    localparam logic [1:0] PLACE_ONLY   = 2'd0;
    localparam logic [1:0] PLACE_HEAD   = 2'd1;
    localparam logic [1:0] PLACE_MIDDLE = 2'd2;
    localparam logic [1:0] PLACE_TAIL   = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [AGE_W-1:0]   age_out;
        logic [1:0]         insert_place;
        logic [COUNT_W-1:0] count;
    } t_out_word;

    // Decoded operation, one-hot
    typedef enum logic [3:0] {
        OP_INSERT = 4'b0001,
        OP_SEARCH = 4'b0010,
        OP_UPDATE = 4'b0100,
        OP_DELETE = 4'b1000
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
    } t_cmd;

    // One table slot
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
    } t_entry;

endpackage

@@ rtl/sorted_key_table.sv @@
`timescale 1ns / 1ps
// One operation at a time runs in the back end; the next command is taken in the cycle
//   after the result loads into the output register.
// A stalled result holds the back end in its finish step until the output register frees.
// Reset: synchronous, active low; empties the table, flushes the command queue.
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of records kept in ascending key order with insert, search, update
// and delete operations.
// ----------------------------------------------------------------------------
//
// The front end decodes each input word and parks it in a two-entry command
// queue, so the input keeps flowing while the back end is busy or while a
// finished result sits in the output register waiting out a stall.
//
// The back end holds the records in a slot memory, slots 0..count-1 valid,
// keys strictly ascending. Each command walks some of these steps, in this order:
//   - scan: read slots upward, one per cycle, and stop at the first key that
//     is not below the target; that slot is the hit or the insertion point
//   - decide: pick the status and, for a good insert, its placement
//   - shift up / shift down: move the tail of the table one slot, one word
//     per cycle, to open or close a gap
//   - put: write the new record or the new age
//   - finish: hand the result to the output register
// A duplicate key is reported ahead of a full table. Slots are never cleared;
// only slots below the record count are ever read.
//
module sorted_key_table import sktbl_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // Command queue between the two halves
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // Accept and decode words; hold up to two pending commands
    sktbl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Execute commands against the slot memory and drive the result word
    sktbl_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

@@ rtl/sktbl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktbl_front
// Accepts input words, decodes the operation and queues the commands.
// ----------------------------------------------------------------------------
module sktbl_front import sktbl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_word i_in_word,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    localparam int QDEPTH = 2;

    t_cmd       r_queue [QDEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    t_cmd       dec_cmd;
    logic       push;

    // Decode the operation code
    always_comb begin
        dec_cmd.key = i_in_word.key;
        dec_cmd.age = i_in_word.age;
        dec_cmd.op  = OP_INSERT;
        unique case (i_in_word.kind)
            KIND_INSERT: dec_cmd.op = OP_INSERT;
            KIND_SEARCH: dec_cmd.op = OP_SEARCH;
            KIND_UPDATE: dec_cmd.op = OP_UPDATE;
            KIND_DELETE: dec_cmd.op = OP_DELETE;
        endcase
    end

    assign o_in_stall  = (r_fill == 2'(QDEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= dec_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, i_cmd_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

@@ rtl/sktbl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktbl_back
// Runs one command at a time against the slot memory: scan, shift, write.
// ----------------------------------------------------------------------------
module sktbl_back import sktbl_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN     = 7'b0000010,
        ST_DECIDE   = 7'b0000100,
        ST_SHIFT_UP = 7'b0001000,
        ST_SHIFT_DN = 7'b0010000,
        ST_PUT      = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } t_state;

    t_entry           mem [TABLE_DEPTH];
    t_entry           r_rdata;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;

    t_state           r_state,   n_state;
    t_cmd             r_cmd,     n_cmd;
    logic [CW-1:0]    r_issue,   n_issue;
    logic [CW-1:0]    r_pos,     n_pos;
    logic [CW-1:0]    r_count,   n_count;
    logic             r_hit,     n_hit;
    logic [AGE_W-1:0] r_hit_age, n_hit_age;
    logic [1:0]       r_status,  n_status;
    logic [AGE_W-1:0] r_age_out, n_age_out;
    logic [1:0]       r_place,   n_place;
    logic             r_out_vld;
    t_out_word        r_out_word;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    t_entry           wr_data;
    logic             out_load;
    logic [CW-1:0]    issue_m1;
    logic [CW+4:0]    count_ext;

    assign issue_m1  = r_issue - CW'(1);
    assign count_ext = {5'b0, r_count};

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_issue   = r_issue;
        n_pos     = r_pos;
        n_count   = r_count;
        n_hit     = r_hit;
        n_hit_age = r_hit_age;
        n_status  = r_status;
        n_age_out = r_age_out;
        n_place   = r_place;
        rd_en     = 1'b0;
        rd_addr   = r_issue[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_pos[AW-1:0];
        wr_data   = '{key: r_cmd.key, age: r_cmd.age};
        o_cmd_pop = 1'b0;
        out_load  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_issue   = '0;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Pipelined ascending scan: stop at first key not below the target
                if (r_count == '0) begin
                    n_pos   = '0;
                    n_hit   = 1'b0;
                    n_state = ST_DECIDE;
                end else if (r_rd_vld && (r_rdata.key >= r_cmd.key)) begin
                    n_pos     = CW'(r_rd_idx);
                    n_hit     = (r_rdata.key == r_cmd.key);
                    n_hit_age = r_rdata.age;
                    n_state   = ST_DECIDE;
                end else if (r_rd_vld && (CW'(r_rd_idx) == r_count - CW'(1))) begin
                    n_pos   = r_count;
                    n_hit   = 1'b0;
                    n_state = ST_DECIDE;
                end else if (r_issue < r_count) begin
                    rd_en   = 1'b1;
                    n_issue = r_issue + CW'(1);
                end
            end
            ST_DECIDE: begin
                n_status  = STATUS_OK;
                n_age_out = '0;
                n_place   = PLACE_ONLY;
                n_state   = ST_FINISH;
                unique case (r_cmd.op)
                    OP_INSERT: begin
                        if (r_hit) begin
                            n_status = STATUS_DUPLICATE;
                        end else if (r_count == CW'(TABLE_DEPTH)) begin
                            n_status = STATUS_FULL;
                        end else begin
                            if (r_count == '0) begin
                                n_place = PLACE_ONLY;
                            end else if (r_pos == '0) begin
                                n_place = PLACE_HEAD;
                            end else if (r_pos == r_count) begin
                                n_place = PLACE_TAIL;
                            end else begin
                                n_place = PLACE_MIDDLE;
                            end
                            n_issue = r_count;
                            n_state = ST_SHIFT_UP;
                        end
                    end
                    OP_SEARCH: begin
                        if (r_hit) begin
                            n_age_out = r_hit_age;
                        end else begin
                            n_status = STATUS_NOT_FOUND;
                        end
                    end
                    OP_UPDATE: begin
                        if (r_hit) begin
                            n_state = ST_PUT;
                        end else begin
                            n_status = STATUS_NOT_FOUND;
                        end
                    end
                    OP_DELETE: begin
                        if (r_hit) begin
                            n_issue = r_pos + CW'(1);
                            n_state = ST_SHIFT_DN;
                        end else begin
                            n_status = STATUS_NOT_FOUND;
                        end
                    end
                endcase
            end
            ST_SHIFT_UP: begin
                // Move slots pos..count-1 up by one, top first
                if (r_issue > r_pos) begin
                    rd_en   = 1'b1;
                    rd_addr = issue_m1[AW-1:0];
                    n_issue = issue_m1;
                end
                if (r_rd_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_idx + AW'(1);
                    wr_data = r_rdata;
                end
                if ((r_issue == r_pos) && !r_rd_vld) begin
                    n_state = ST_PUT;
                end
            end
            ST_SHIFT_DN: begin
                // Close the gap: move slots pos+1..count-1 down by one
                if (r_issue < r_count) begin
                    rd_en   = 1'b1;
                    n_issue = r_issue + CW'(1);
                end
                if (r_rd_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_idx - AW'(1);
                    wr_data = r_rdata;
                end
                if ((r_issue >= r_count) && !r_rd_vld) begin
                    n_count = r_count - CW'(1);
                    n_state = ST_FINISH;
                end
            end
            ST_PUT: begin
                wr_en = 1'b1;
                if (r_cmd.op == OP_INSERT) begin
                    n_count = r_count + CW'(1);
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_vld || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        r_rd_idx <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_issue   <= n_issue;
        r_pos     <= n_pos;
        r_hit     <= n_hit;
        r_hit_age <= n_hit_age;
        r_status  <= n_status;
        r_age_out <= n_age_out;
        r_place   <= n_place;
        if (out_load) begin
            r_out_word <= '{status:       r_status,
                            age_out:      r_age_out,
                            insert_place: r_place,
                            count:        count_ext[COUNT_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= rd_en;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

@@ rtl/sktbl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktbl_checker
// Port-level checks on the sorted key table, bound to the top level.
// ----------------------------------------------------------------------------
module sktbl_checker import sktbl_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // Reset empties the queue and the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("output or queue not cleared by reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

    // A failed operation carries no age and no placement
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != STATUS_OK))
        |-> ((o_out_word.age_out == '0) && (o_out_word.insert_place == PLACE_ONLY)))
        else $error("failed operation reports age or placement");

    // A placement other than the only entry is reported only with an OK status
    a_place_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.insert_place != PLACE_ONLY))
        |-> (o_out_word.status == STATUS_OK))
        else $error("placement reported on a failed insert");

endmodule

bind sorted_key_table sktbl_checker u_sktbl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

@@ tb/sorted_key_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_checker
// Watches both channels of the sorted key table, keeps its own copy of the
// table, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module sorted_key_table_checker import sktbl_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    // Shadow table: slots below held_count are valid, keys ascending
    logic [KEY_W-1:0] shadow_key [TABLE_DEPTH];
    logic [AGE_W-1:0] shadow_age [TABLE_DEPTH];
    int unsigned      held_count = 0;

    t_out_word expected_results [$];
    int        mismatch_count = 0;
    int        pending_count  = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_count;

    // Apply one operation to the shadow table and return its result word
    function automatic t_out_word apply_table_op(input t_in_word w);
        t_out_word   r;
        int unsigned pos;
        bit          hit;
        r = '0;
        r.status = STATUS_OK;
        pos = 0;
        while (pos < held_count && shadow_key[pos] < w.key)
            pos++;
        hit = (pos < held_count) && (shadow_key[pos] == w.key);
        case (w.kind)
            KIND_INSERT: begin
                if (hit) begin
                    r.status = STATUS_DUPLICATE;
                end else if (held_count >= TABLE_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    if (held_count == 0)
                        r.insert_place = PLACE_ONLY;
                    else if (pos == 0)
                        r.insert_place = PLACE_HEAD;
                    else if (pos == held_count)
                        r.insert_place = PLACE_TAIL;
                    else
                        r.insert_place = PLACE_MIDDLE;
                    for (int i = held_count; i > pos; i--) begin
                        shadow_key[i] = shadow_key[i-1];
                        shadow_age[i] = shadow_age[i-1];
                    end
                    shadow_key[pos] = w.key;
                    shadow_age[pos] = w.age;
                    held_count++;
                end
            end
            KIND_SEARCH: begin
                if (hit)
                    r.age_out = shadow_age[pos];
                else
                    r.status = STATUS_NOT_FOUND;
            end
            KIND_UPDATE: begin
                if (hit)
                    shadow_age[pos] = w.age;
                else
                    r.status = STATUS_NOT_FOUND;
            end
            default: begin
                if (hit) begin
                    for (int i = pos; i + 1 < held_count; i++) begin
                        shadow_key[i] = shadow_key[i+1];
                        shadow_age[i] = shadow_age[i+1];
                    end
                    held_count--;
                end else begin
                    r.status = STATUS_NOT_FOUND;
                end
            end
        endcase
        r.count = COUNT_W'(held_count);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            held_count = 0;
            expected_results.delete();
        end else begin
            // Retire the oldest expectation before queuing a new one
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no expectation pending");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, i_out_word.status);
                    check_field("age_out", want.age_out, i_out_word.age_out);
                    check_field("insert_place", want.insert_place,
                                i_out_word.insert_place);
                    check_field("count", want.count, i_out_word.count);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(apply_table_op(i_in_word));
        end
        pending_count = expected_results.size();
    end

endmodule

@@ tb/tb_sorted_key_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_table
// Drives operation words into the sorted key table with random gaps and
// output stalls; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_sorted_key_table;
    import sktbl_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int TABLE_DEPTH     = 16;
    localparam int RESET_CYCLES    = 10;
    localparam int PHASES          = 11;
    localparam int PHASE_ITEMS     = 150;
    localparam int POOL_MAX        = 24;
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver hold-off, fills the block
    localparam int DRAIN_CYCLES    = 60;    // about two full scans plus a shift
    localparam int IDLE_LIMIT      = 3000;  // hold-off plus worst latency, several times

    localparam logic [KEY_W-1:0] KEY_MAX = 31'h7FFF_FFFF;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    bit random_phase  = 1'b0;
    bit pressure_done = 1'b0;

    // Keys for one phase; every stored key comes from here so a drain empties it
    logic [KEY_W-1:0] key_pool [POOL_MAX];
    int               pool_size;

    always #CLK_HALF clk = ~clk;

    sorted_key_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    sorted_key_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one word, after an optional gap, and hold it until accepted.
    // Called at a rising edge; returns at the edge that took the word.
    task automatic send_op(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [AGE_W-1:0] age);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            gap = 0;
        else if (pick < 85)
            gap = $urandom_range(1, 3);
        else if (pick < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_word.kind <= kind;
        in_word.key  <= key;
        in_word.age  <= age;
        // Hold the word steady while the block stalls
        do @(posedge clk); while (in_stall);
    endtask

    // Receiver: alternate runs of readiness with stalls of random length.
    // Both lengths are at least one, so stall changes once per edge at most.
    always begin
        int run_len;
        int hold_len;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            run_len = $urandom_range(1, 4);
        else if (pick < 80)
            run_len = $urandom_range(5, 30);
        else
            run_len = $urandom_range(50, 300);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            hold_len = $urandom_range(1, 3);
        else if (pick < 95)
            hold_len = $urandom_range(4, 15);
        else
            hold_len = $urandom_range(30, 80);
        // Once the random traffic runs, hold off long enough to back up the input
        if (random_phase && !pressure_done) begin
            hold_len      = HOLD_OFF_CYCLES;
            pressure_done = 1'b1;
        end
        out_stall <= 1'b0;
        repeat (run_len) @(posedge clk);
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
    end

    // Watchdog: count edges with no word moving on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** sorted_key_table: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int pick;
        int ins_weight;
        logic [1:0] kind;
        logic [KEY_W-1:0] key;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, every placement, key zero and the top key
        send_op(KIND_SEARCH, 31'd5, 8'h00);
        send_op(KIND_UPDATE, 31'd5, 8'h11);
        send_op(KIND_DELETE, 31'd5, 8'h00);
        send_op(KIND_INSERT, 31'd100, 8'hFF);     // only entry
        send_op(KIND_INSERT, 31'd0, 8'h00);       // new head, key zero
        send_op(KIND_INSERT, KEY_MAX, 8'hA5);     // tail, largest key
        send_op(KIND_INSERT, 31'd50, 8'h5A);      // middle
        send_op(KIND_INSERT, 31'd100, 8'h77);     // duplicate
        send_op(KIND_SEARCH, 31'd0, 8'hFF);
        send_op(KIND_SEARCH, KEY_MAX, 8'h00);
        send_op(KIND_UPDATE, 31'd50, 8'h3C);
        send_op(KIND_SEARCH, 31'd50, 8'h00);
        send_op(KIND_SEARCH, 31'd51, 8'h00);      // miss between keys
        send_op(KIND_UPDATE, KEY_MAX - 31'd1, 8'h01);
        send_op(KIND_DELETE, 31'd0, 8'h00);       // remove head
        send_op(KIND_DELETE, 31'd50, 8'h00);
        send_op(KIND_DELETE, KEY_MAX, 8'h00);     // remove tail
        send_op(KIND_DELETE, 31'd100, 8'h00);     // back to empty
        send_op(KIND_DELETE, 31'd100, 8'h00);

        random_phase = 1'b1;

        // Random phases: fill and churn a table from a small key pool, alternating
        // insert-heavy mixes with ones that weigh inserts and deletes alike, then drain it.
        for (int phase = 0; phase < PHASES; phase++) begin
            pool_size  = (phase == 0) ? POOL_MAX : $urandom_range(10, POOL_MAX);
            ins_weight = (phase % 2 == 0) ? 50 : 30;
            for (int i = 0; i < pool_size; i++) begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    key_pool[i] = KEY_W'($urandom_range(0, 40));
                else if (pick == 1)
                    key_pool[i] = KEY_MAX - KEY_W'($urandom_range(0, 40));
                else
                    key_pool[i] = KEY_W'($urandom());
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                key  = key_pool[$urandom_range(0, pool_size - 1)];
                if (pick < 5) begin
                    // Noise: any key, never stored
                    kind = KIND_SEARCH + 2'($urandom_range(0, 2));
                    key  = KEY_W'($urandom());
                end else if (pick < 5 + ins_weight) begin
                    kind = KIND_INSERT;
                end else if (pick < 25 + ins_weight) begin
                    kind = KIND_SEARCH;
                end else if (pick < 40 + ins_weight) begin
                    kind = KIND_UPDATE;
                end else begin
                    kind = KIND_DELETE;
                end
                send_op(kind, key, AGE_W'($urandom_range(0, 255)));
            end

            // Drain: remove every pool key so the next phase starts empty
            for (int i = 0; i < pool_size; i++)
                send_op(KIND_DELETE, key_pool[i], AGE_W'($urandom_range(0, 255)));
        end

        in_valid <= 1'b0;

        // Let every outstanding result arrive, then watch for strays.
        // Step one edge first so the count includes the last accepted word.
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("** sorted_key_table: PASSED **");
        else
            $display("** sorted_key_table: FAILED **");
        $finish;
    end

endmodule

@@ sorted_key_table.f @@
rtl/sktbl_pkg.sv
rtl/sktbl_front.sv
rtl/sktbl_back.sv
rtl/sorted_key_table.sv
rtl/sktbl_checker.sv
tb/sorted_key_table_checker.sv
tb/tb_sorted_key_table.sv
